[sv/tcmq_pkg.sv]
package tcmq_pkg;

  // field widths
  localparam int TYPE_W     = 8;
  localparam int PAYLOAD_W  = 32;
  localparam int TICK_W     = 24;
  localparam int IMP_CNT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IMP_SLOTS  = 4;

  // default sizes
  localparam int NORMAL_LIMIT_DEF = 63;
  localparam int URGENT_DEPTH_DEF = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // fixed message types
  localparam logic [TYPE_W-1:0] FIXED_IMPORTANT = 8'd34;
  localparam logic [TYPE_W-1:0] IDLE_TYPE       = 8'd33;

  localparam logic [TICK_W-1:0] TICK_MAX          = '1;
  localparam logic [TICK_W-1:0] SEND_INTERVAL_RST = 24'd1000;

  // item operation codes
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_POLL = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_A   = 3'd0,
    REG_TYPE_B   = 3'd1,
    REG_TYPE_C   = 3'd2,
    REG_TYPE_D   = 3'd3,
    REG_IMP_CNT  = 3'd4,
    REG_INTERVAL = 3'd5
  } cfg_reg_t;

endpackage

[sv/tcmq_in_if.sv]
interface tcmq_in_if import tcmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  mode_t                mode;
  logic [TYPE_W-1:0]    msg_type;
  logic [PAYLOAD_W-1:0] msg_payload;

  modport source (output valid, output mode, output msg_type, output msg_payload,
                  input ready);
  modport sink   (input valid, input mode, input msg_type, input msg_payload,
                  output ready);
endinterface

[sv/tcmq_out_if.sv]
interface tcmq_out_if import tcmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    out_type;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 was_important;
  logic                 send_ready;
  logic                 important_dropped;

  modport source (output valid, output out_type, output out_payload,
                  output was_important, output send_ready, output important_dropped,
                  input ready);
  modport sink   (input valid, input out_type, input out_payload,
                  input was_important, input send_ready, input important_dropped,
                  output ready);
endinterface

[sv/tcmq_cfg_if.sv]
interface tcmq_cfg_if import tcmq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tcmq_cell.sv]
module tcmq_cell #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         load,
  input  logic         shift,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] next_data,
  output logic [W-1:0] data_q
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  // take a new entry, or the neighbor's entry on a pop
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[sv/tcmq_fifo.sv]
module tcmq_fifo #(
  parameter int DEPTH = 64,
  parameter int W     = 40,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          clr,
  input  logic          pop,
  input  logic [W-1:0]  push_data,
  output logic [W-1:0]  head_data,
  output logic [CW-1:0] count
);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] wr_idx;
  logic [W-1:0]  cell_q [DEPTH];

  // write slot: first free cell, or the first cell when emptied before the push
  assign wr_idx = clr ? '0 : count_r;

  // row of cells, each but the last pulling from its upper neighbor on a pop
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] upper;
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_mid
      assign upper = cell_q[i+1];
    end
    tcmq_cell #(.W(W)) u_cell (
      .clk       (clk),
      .load      (push && (wr_idx == CW'(i))),
      .shift     (pop),
      .load_data (push_data),
      .next_data (upper),
      .data_q    (cell_q[i])
    );
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = wr_idx + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_data = cell_q[0];
  assign count     = count_r;

endmodule

[sv/two_class_message_queue.sv]
// channel | dir | handshake     | carries
// in_if   | in  | valid/ready   | mode, msg_type, msg_payload
// out_if  | out | valid/ready   | out_type, out_payload, was_important, send_ready,
//         |     |               | important_dropped
// cfg_if  | in  | valid/ready   | index, data (ready always high)
//
// Each item is executed as it is accepted: one item per cycle is accepted whenever the
// result register is empty or being drained; pushes and ticks give no result.
// Both queues are rows of shift cells, a pop moves every cell one place toward the
// head in that same cycle. Reset (rst_n low at a clock edge) empties both queues,
// clears the tick counter and drop flag and loads the register defaults; no sweep.
// A stalled result holds the input off until it is taken.
module two_class_message_queue import tcmq_pkg::*; #(
  parameter int NORMAL_LIMIT = NORMAL_LIMIT_DEF,
  parameter int URGENT_DEPTH = URGENT_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tcmq_in_if.sink    in_if,
  tcmq_out_if.source out_if,
  tcmq_cfg_if.sink   cfg_if
);

  localparam int STORE_BITS   = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int ENTRY_W      = TYPE_W + STORE_BITS;
  localparam int NORMAL_DEPTH = NORMAL_LIMIT + 1;
  localparam int UCW          = $clog2(URGENT_DEPTH + 1);
  localparam int NCW          = $clog2(NORMAL_DEPTH + 1);

  // configuration registers
  logic [TYPE_W-1:0]    imp_type_r [IMP_SLOTS];
  logic [IMP_CNT_W-1:0] imp_cnt_r;
  logic [TICK_W-1:0]    interval_r;

  // block state
  logic [TICK_W-1:0]    ticks_r, ticks_nxt;
  logic                 drop_r, drop_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [TYPE_W-1:0]    out_type_r, out_type_nxt;
  logic [PAYLOAD_W-1:0] out_payload_r, out_payload_nxt;
  logic                 was_imp_r, was_imp_nxt;
  logic                 send_ready_r, send_ready_nxt;
  logic                 dropped_r, dropped_nxt;

  logic                 accept;
  logic                 important;
  logic [ENTRY_W-1:0]   entry;

  logic                 u_push, u_pop, n_push, n_pop, n_clr;
  logic [ENTRY_W-1:0]   u_head, n_head;
  logic [UCW-1:0]       u_count;
  logic [NCW-1:0]       n_count;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign entry        = {in_if.msg_type, in_if.msg_payload[STORE_BITS-1:0]};

  // classification against the fixed type and the enabled configured types
  always_comb begin
    important = (in_if.msg_type == FIXED_IMPORTANT);
    for (int i = 0; i < IMP_SLOTS; i++) begin
      if ((imp_cnt_r > IMP_CNT_W'(i)) && (imp_type_r[i] == in_if.msg_type)) begin
        important = 1'b1;
      end
    end
  end

  // queue controls
  always_comb begin
    u_push = 1'b0;
    u_pop  = 1'b0;
    n_push = 1'b0;
    n_pop  = 1'b0;
    n_clr  = (n_count > NCW'(NORMAL_LIMIT));
    if (accept) begin
      unique case (in_if.mode)
        MODE_PUSH: begin
          u_push = important && (u_count < UCW'(URGENT_DEPTH));
          n_push = !important;
        end
        MODE_POP: begin
          u_pop = (u_count != '0);
          n_pop = (u_count == '0) && (n_count != '0);
        end
        default: begin
        end
      endcase
    end
  end

  tcmq_fifo #(.DEPTH(URGENT_DEPTH), .W(ENTRY_W)) u_urgent (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (u_push),
    .clr       (1'b0),
    .pop       (u_pop),
    .push_data (entry),
    .head_data (u_head),
    .count     (u_count)
  );

  tcmq_fifo #(.DEPTH(NORMAL_DEPTH), .W(ENTRY_W)) u_normal (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (n_push),
    .clr       (n_clr),
    .pop       (n_pop),
    .push_data (entry),
    .head_data (n_head),
    .count     (n_count)
  );

  // item execution and result formation
  always_comb begin
    ticks_nxt       = ticks_r;
    drop_nxt        = drop_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_type_nxt    = out_type_r;
    out_payload_nxt = out_payload_r;
    was_imp_nxt     = was_imp_r;
    send_ready_nxt  = send_ready_r;
    dropped_nxt     = dropped_r;
    if (accept) begin
      unique case (in_if.mode)
        MODE_PUSH: begin
          if (important && (u_count >= UCW'(URGENT_DEPTH))) begin
            drop_nxt = 1'b1;
          end
        end
        MODE_TICK: begin
          if (ticks_r != TICK_MAX) begin
            ticks_nxt = ticks_r + TICK_W'(1);
          end
        end
        MODE_POP: begin
          out_valid_nxt  = 1'b1;
          send_ready_nxt = 1'b0;
          dropped_nxt    = drop_r;
          if (u_count != '0) begin
            out_type_nxt    = u_head[ENTRY_W-1 -: TYPE_W];
            out_payload_nxt = PAYLOAD_W'(u_head[STORE_BITS-1:0]);
            was_imp_nxt     = 1'b1;
          end else if (n_count != '0) begin
            out_type_nxt    = n_head[ENTRY_W-1 -: TYPE_W];
            out_payload_nxt = PAYLOAD_W'(n_head[STORE_BITS-1:0]);
            was_imp_nxt     = 1'b0;
          end else begin
            out_type_nxt    = IDLE_TYPE;
            out_payload_nxt = '0;
            was_imp_nxt     = 1'b0;
          end
        end
        MODE_POLL: begin
          out_valid_nxt   = 1'b1;
          out_type_nxt    = '0;
          out_payload_nxt = '0;
          was_imp_nxt     = 1'b0;
          dropped_nxt     = drop_r;
          send_ready_nxt  = (ticks_r >= interval_r);
          if (ticks_r >= interval_r) begin
            ticks_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ticks_r     <= ticks_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_type_r    <= out_type_nxt;
    out_payload_r <= out_payload_nxt;
    was_imp_r     <= was_imp_nxt;
    send_ready_r  <= send_ready_nxt;
    dropped_r     <= dropped_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IMP_SLOTS; i++) begin
        imp_type_r[i] <= '0;
      end
      imp_cnt_r  <= '0;
      interval_r <= SEND_INTERVAL_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        REG_TYPE_A:   imp_type_r[0] <= cfg_if.data[TYPE_W-1:0];
        REG_TYPE_B:   imp_type_r[1] <= cfg_if.data[TYPE_W-1:0];
        REG_TYPE_C:   imp_type_r[2] <= cfg_if.data[TYPE_W-1:0];
        REG_TYPE_D:   imp_type_r[3] <= cfg_if.data[TYPE_W-1:0];
        REG_IMP_CNT:  imp_cnt_r     <= cfg_if.data[IMP_CNT_W-1:0];
        REG_INTERVAL: interval_r    <= cfg_if.data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.out_type          = out_type_r;
  assign out_if.out_payload       = out_payload_r;
  assign out_if.was_important     = was_imp_r;
  assign out_if.send_ready        = send_ready_r;
  assign out_if.important_dropped = dropped_r;

endmodule

[sim/tb_top.sv]
module tb_top import tcmq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [TYPE_W-1:0]    mtype;
    logic [PAYLOAD_W-1:0] payload;
  } msg_t;

  typedef struct packed {
    logic [TYPE_W-1:0]    otype;
    logic [PAYLOAD_W-1:0] payload;
    logic                 urgent;
    logic                 sent;
    logic                 dropped;
  } result_t;

  typedef enum {MIXED, TIMING, FILL_NORMAL, FILL_URGENT, DRAIN} phase_kind_t;

  // priority queue predictor and result checker
  class prio_queue_checker;
    logic [TYPE_W-1:0]    imp_type [IMP_SLOTS];
    logic [IMP_CNT_W-1:0] imp_count;
    logic [TICK_W-1:0]    interval;
    logic [TICK_W-1:0]    ticks;
    bit                   dropped;
    msg_t                 urgent_q[$];
    msg_t                 normal_q[$];
    result_t              expected_out[$];
    int unsigned          errors;

    function new();
      foreach (imp_type[i]) imp_type[i] = '0;
      imp_count = '0;
      interval  = SEND_INTERVAL_RST;
      ticks     = '0;
      dropped   = 1'b0;
      errors    = 0;
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TYPE_A:   imp_type[0] = data[TYPE_W-1:0];
        REG_TYPE_B:   imp_type[1] = data[TYPE_W-1:0];
        REG_TYPE_C:   imp_type[2] = data[TYPE_W-1:0];
        REG_TYPE_D:   imp_type[3] = data[TYPE_W-1:0];
        REG_IMP_CNT:  imp_count   = data[IMP_CNT_W-1:0];
        REG_INTERVAL: interval    = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // fixed type or one of the configured types in use; count saturates at four
    function bit is_urgent(logic [TYPE_W-1:0] t);
      int n;
      n = (imp_count > IMP_SLOTS) ? IMP_SLOTS : imp_count;
      if (t == FIXED_IMPORTANT) return 1'b1;
      for (int i = 0; i < n; i++)
        if (imp_type[i] == t) return 1'b1;
      return 1'b0;
    endfunction

    function void take_item(mode_t m, logic [TYPE_W-1:0] t, logic [PAYLOAD_W-1:0] p);
      result_t r;
      msg_t    e;
      r = '0;
      e.mtype   = t;
      e.payload = p;
      case (m)
        MODE_PUSH: begin
          if (is_urgent(t)) begin
            // full urgent queue drops the item and sets the sticky flag
            if (urgent_q.size() >= URGENT_DEPTH_DEF) dropped = 1'b1;
            else urgent_q = {urgent_q, e};
          end else begin
            // normal queue past its limit is flushed first
            if (normal_q.size() > NORMAL_LIMIT_DEF) normal_q.delete();
            normal_q = {normal_q, e};
          end
        end
        MODE_TICK: begin
          if (ticks != TICK_MAX) ticks = ticks + TICK_W'(1);
        end
        MODE_POP: begin
          if (urgent_q.size() != 0) begin
            e = urgent_q[0];
            urgent_q.delete(0);
            r.otype   = e.mtype;
            r.payload = e.payload;
            r.urgent  = 1'b1;
          end else if (normal_q.size() != 0) begin
            e = normal_q[0];
            normal_q.delete(0);
            r.otype   = e.mtype;
            r.payload = e.payload;
          end else begin
            r.otype = IDLE_TYPE;
          end
          r.dropped = dropped;
          expected_out = {expected_out, r};
        end
        MODE_POLL: begin
          if (ticks >= interval) begin
            ticks  = '0;
            r.sent = 1'b1;
          end
          r.dropped = dropped;
          expected_out = {expected_out, r};
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %h got %h", field, want, got);
      end
    endfunction

    function void check_result(logic [TYPE_W-1:0] otype, logic [PAYLOAD_W-1:0] payload,
                               logic urgent, logic sent, logic dropped_flag);
      result_t want;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: type %h payload %h", otype, payload);
        return;
      end
      want = expected_out[0];
      expected_out.delete(0);
      compare("out_type", 32'(want.otype), 32'(otype));
      compare("out_payload", 32'(want.payload), 32'(payload));
      compare("was_important", 32'(want.urgent), 32'(urgent));
      compare("send_ready", 32'(want.sent), 32'(sent));
      compare("important_dropped", 32'(want.dropped), 32'(dropped_flag));
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_cnt = 0;
  bit          steady;

  logic [TYPE_W-1:0]    cur_type [IMP_SLOTS];
  logic [IMP_CNT_W-1:0] cur_count;
  logic [TICK_W-1:0]    cur_interval;

  prio_queue_checker sb = new();

  tcmq_in_if  in_ch();
  tcmq_out_if out_ch();
  tcmq_cfg_if cfg_ch();

  two_class_message_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.apply_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.take_item(in_ch.mode, in_ch.msg_type, in_ch.msg_payload);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_type, out_ch.out_payload, out_ch.was_important,
                        out_ch.send_ready, out_ch.important_dropped);
    end
  end

  // result side stalls: mostly open, short stalls, a few long ones
  initial begin : result_sink
    int hold;
    forever begin
      hold = $urandom_range(0, 9);
      if (hold < 6) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (hold < 9) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic mode_t pick_mode(phase_kind_t kind);
    int r;
    int w_push;
    int w_pop;
    int w_tick;
    r = $urandom_range(0, 99);
    case (kind)
      TIMING:      begin w_push = 15; w_pop = 15; w_tick = 50; end
      FILL_NORMAL: begin w_push = 85; w_pop = 8;  w_tick = 4;  end
      FILL_URGENT: begin w_push = 85; w_pop = 8;  w_tick = 4;  end
      DRAIN:       begin w_push = 15; w_pop = 70; w_tick = 8;  end
      default:     begin w_push = 40; w_pop = 35; w_tick = 15; end
    endcase
    if (r < w_push) return MODE_PUSH;
    if (r < w_push + w_pop) return MODE_POP;
    if (r < w_push + w_pop + w_tick) return MODE_TICK;
    return MODE_POLL;
  endfunction

  // either a type that lands in the urgent queue or mostly anything
  function automatic logic [TYPE_W-1:0] pick_type(int urgent_pct);
    int in_use;
    int k;
    in_use = (cur_count > IMP_SLOTS) ? IMP_SLOTS : cur_count;
    if ($urandom_range(0, 99) < urgent_pct) begin
      k = $urandom_range(0, in_use);
      return (k == in_use) ? FIXED_IMPORTANT : cur_type[k];
    end
    if ($urandom_range(0, 9) == 0) return IDLE_TYPE;
    return TYPE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one item, held until taken, then maybe an idle gap
  task automatic send_item(mode_t m, logic [TYPE_W-1:0] t, logic [PAYLOAD_W-1:0] p);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.msg_type    <= t;
    in_ch.msg_payload <= p;
    do @(posedge clk); while (!in_ch.ready);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // write every register from the current settings, unused upper bits random
  task automatic configure();
    write_reg(REG_TYPE_A, {16'($urandom), cur_type[0]});
    write_reg(REG_TYPE_B, {16'($urandom), cur_type[1]});
    write_reg(REG_TYPE_C, {16'($urandom), cur_type[2]});
    write_reg(REG_TYPE_D, {16'($urandom), cur_type[3]});
    write_reg(REG_IMP_CNT, {21'($urandom), cur_count});
    write_reg(REG_INTERVAL, cur_interval);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // main sequence
  initial begin : stimulus
    phase_kind_t plan [12];
    int          n;
    int          urgent_pct;
    plan = '{MIXED, TIMING, FILL_NORMAL, DRAIN, MIXED, FILL_NORMAL,
             TIMING, DRAIN, FILL_URGENT, MIXED, FILL_URGENT, DRAIN};
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_PUSH;
    in_ch.msg_type    <= '0;
    in_ch.msg_payload <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_TYPE_A;
    cfg_ch.data       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: only the fixed type is important
    steady = 1'b1;
    send_item(MODE_PUSH, FIXED_IMPORTANT, '1);
    send_item(MODE_PUSH, 8'd0, '0);
    send_item(MODE_PUSH, 8'd255, 32'hA5A5_5A5A);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_POLL, '0, '0);
    send_item(MODE_TICK, '0, '0);
    drain();

    // count above four saturates, idle type made important, zero interval
    cur_type     = '{8'd255, 8'd0, IDLE_TYPE, FIXED_IMPORTANT};
    cur_count    = 3'd7;
    cur_interval = '0;
    configure();
    send_item(MODE_PUSH, IDLE_TYPE, 32'h0000_0001);
    send_item(MODE_PUSH, 8'd0, '1);
    send_item(MODE_PUSH, 8'd1, 32'h8000_0000);
    send_item(MODE_PUSH, 8'd255, 32'h5A5A_A5A5);
    send_item(MODE_POLL, '0, '0);
    repeat (5) send_item(MODE_POP, '0, '0);
    drain();

    // largest interval, no configured types
    cur_count    = '0;
    cur_interval = '1;
    configure();
    send_item(MODE_TICK, '0, '0);
    send_item(MODE_POLL, '0, '0);
    send_item(MODE_PUSH, 8'd255, '1);
    send_item(MODE_POP, '0, '0);
    drain();

    // random phases, each under its own settings
    foreach (plan[ph]) begin
      foreach (cur_type[i]) begin
        if ($urandom_range(0, 3) == 0) cur_type[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else cur_type[i] = TYPE_W'($urandom_range(0, 255));
      end
      cur_count = IMP_CNT_W'($urandom_range(0, 7));
      if (plan[ph] == TIMING) begin
        cur_interval = TICK_W'($urandom_range(0, 6));
      end else begin
        case ($urandom_range(0, 3))
          0:       cur_interval = '0;
          1:       cur_interval = '1;
          default: cur_interval = TICK_W'($urandom_range(0, 12));
        endcase
      end
      configure();
      steady = ($urandom_range(0, 3) == 0);
      n = (plan[ph] == FILL_NORMAL || plan[ph] == FILL_URGENT) ? 130 : 110;
      case (plan[ph])
        FILL_URGENT: urgent_pct = 80;
        FILL_NORMAL: urgent_pct = 5;
        default:     urgent_pct = 40;
      endcase
      repeat (n) send_item(pick_mode(plan[ph]), pick_type(urgent_pct), pick_payload());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tcmq_pkg.sv
sv/tcmq_in_if.sv
sv/tcmq_out_if.sv
sv/tcmq_cfg_if.sv
sv/tcmq_cell.sv
sv/tcmq_fifo.sv
sv/two_class_message_queue.sv
sim/tb_top.sv
